/* rtl/core/lfulru_pkg.sv */
// Shared types and constants for the LFU cache with LRU tie-break.
// Controller state, command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lfulru_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESPOND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic decide;
        logic update;
        logic respond;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep_done;
        logic need_update;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/lfu_cache_with_lru_tiebreak_top.sv */
// LFU cache, LRU tie-break. One item at a time: accept, scan sweep over all
// entries, decision, update sweep over all entries (skipped on a get miss or a
// put at capacity zero), response. The next item is taken only after the
// response, and a stalled result holds the response. The sweeps read the entry
// memory through its single read port. Reset clears valid bits, fill count and
// output valid, and sets capacity to 16.
`default_nettype none

module lfu_cache_with_lru_tiebreak_top
    import lfulru_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              action,
    input  wire logic [KEY_W-1:0]  lookup_key,
    input  wire logic [DATA_W-1:0] write_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   found,
    output logic [DATA_W-1:0]      read_value,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CAP_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lfulru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lfulru_dp #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .action     (action),
        .lookup_key (lookup_key),
        .write_data (write_data),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .found      (found),
        .read_value (read_value)
    );

    // a transfer in starts a scan, and the input stays stalled while it runs
    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again before scan completed");

    // misses and puts return zero data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> read_value == '0)
        else $error("non-zero read_value without a hit");

    // no result appears while an item is still being scanned
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result produced in the cycle after a transfer in");

endmodule

`default_nettype wire

/* rtl/core/lfulru_ctrl.sv */
// Controller state machine: sequences scan, decision, update sweep and response.
// Depends on lfulru_pkg.
`default_nettype none

module lfulru_ctrl
    import lfulru_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = status.need_update ? ST_UPDATE : ST_RESPOND;
            end
            ST_UPDATE:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_RESPOND:
            begin
                cmd.respond = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/lfulru_dp.sv */
// Datapath: entry memory, valid bits, scan comparators, victim tracking,
// rank update sweep, capacity register and output register. Uses lfulru_pkg.
`default_nettype none

module lfulru_dp
    import lfulru_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              action,
    input  wire logic [KEY_W-1:0]  lookup_key,
    input  wire logic [DATA_W-1:0] write_data,
    input  wire logic              cfg_valid,
    input  wire logic [CAP_W-1:0]  cfg_data,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   found,
    output logic [DATA_W-1:0]      read_value
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CTRW = $clog2(ENTRIES + 1);
    localparam int CMPW = (CTRW > CAP_W) ? CTRW : CAP_W;
    localparam int WW   = KEY_W + DATA_W + COUNT_WIDTH + RW;
    localparam int C_LO = RW;
    localparam int D_LO = RW + COUNT_WIDTH;
    localparam int K_LO = D_LO + DATA_W;

    localparam logic [CTRW-1:0]        CTR_END   = CTRW'(ENTRIES);
    localparam logic [CMPW-1:0]        ENT_CMP   = CMPW'(ENTRIES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // entry word: {key, data, count, rank}
    logic [WW-1:0]          mem [ENTRIES];
    logic [WW-1:0]          rd_word_reg;
    logic [CTRW-1:0]        ctr_reg;
    logic                   pv_reg;
    logic [IW-1:0]          pidx_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic [CTRW-1:0]        filled_reg;
    logic [CAP_W-1:0]       capacity_reg;

    logic                   act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [DATA_W-1:0]      data_reg;

    logic                   hit_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg;
    logic [RW-1:0]          hit_rank_reg;
    logic [DATA_W-1:0]      hit_data_reg;
    logic                   vic_found_reg;
    logic [IW-1:0]          vic_idx_reg;
    logic [COUNT_WIDTH-1:0] vic_cnt_reg;
    logic [RW-1:0]          vic_rank_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;

    logic [IW-1:0]          tgt_reg;
    logic [RW-1:0]          thr_reg;
    logic                   all_reg;
    logic [DATA_W-1:0]      new_data_reg;
    logic [COUNT_WIDTH-1:0] new_cnt_reg;
    logic                   res_found_reg;
    logic [DATA_W-1:0]      res_value_reg;

    logic                   out_valid_reg;
    logic                   found_reg;
    logic [DATA_W-1:0]      read_value_reg;

    logic [KEY_W-1:0]       rd_key;
    logic [DATA_W-1:0]      rd_data;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [RW-1:0]          rd_rank;
    logic                   rd_valid;

    logic [CMPW-1:0]        cap_ext;
    logic [CMPW-1:0]        cap_eff;
    logic                   is_put;
    logic                   need_update;
    logic                   evict;
    logic [IW-1:0]          tgt_next;
    logic [ENTRIES-1:0]     valid_next;
    logic                   wr_en;
    logic [WW-1:0]          wr_word;
    logic                   out_free;

    assign rd_key   = rd_word_reg[K_LO +: KEY_W];
    assign rd_data  = rd_word_reg[D_LO +: DATA_W];
    assign rd_cnt   = rd_word_reg[C_LO +: COUNT_WIDTH];
    assign rd_rank  = rd_word_reg[RW-1:0];
    assign rd_valid = valid_reg[pidx_reg];

    // sweep counter; read data is registered and returns in the cycle after the address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg  <= '0;
            pv_reg   <= 1'b0;
            pidx_reg <= '0;
        end
        else if (cmd.start || cmd.decide)
        begin
            ctr_reg <= '0;
            pv_reg  <= 1'b0;
        end
        else if (cmd.scan || cmd.update)
        begin
            pv_reg   <= (ctr_reg != CTR_END);
            pidx_reg <= ctr_reg[IW-1:0];
            if (ctr_reg != CTR_END)
            begin
                ctr_reg <= ctr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctr_reg != CTR_END)
        begin
            rd_word_reg <= mem[ctr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pidx_reg] <= wr_word;
        end
    end

    // scan: key match, least-used oldest victim, first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= ACT_GET;
            hit_reg        <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            act_reg        <= action;
            key_reg        <= lookup_key;
            data_reg       <= write_data;
            hit_reg        <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.scan && pv_reg)
        begin
            if (rd_valid)
            begin
                if (rd_key == key_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= pidx_reg;
                    hit_cnt_reg  <= rd_cnt;
                    hit_rank_reg <= rd_rank;
                    hit_data_reg <= rd_data;
                end
                if (!vic_found_reg || rd_cnt < vic_cnt_reg ||
                    (rd_cnt == vic_cnt_reg && rd_rank > vic_rank_reg))
                begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= pidx_reg;
                    vic_cnt_reg   <= rd_cnt;
                    vic_rank_reg  <= rd_rank;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= pidx_reg;
            end
        end
    end

    // decision
    always_comb
    begin
        cap_ext     = CMPW'(capacity_reg);
        cap_eff     = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
        is_put      = (act_reg == ACT_PUT);
        need_update = is_put ? (cap_eff != '0) : hit_reg;
        evict       = !hit_reg && vic_found_reg && (CMPW'(filled_reg) >= cap_eff);
        priority if (hit_reg)
        begin
            tgt_next = hit_idx_reg;
        end
        else if (evict && !(free_found_reg && free_idx_reg < vic_idx_reg))
        begin
            tgt_next = vic_idx_reg;
        end
        else
        begin
            tgt_next = free_idx_reg;
        end
        valid_next = valid_reg;
        if (need_update && !hit_reg)
        begin
            // evict and insert may hit the same slot: the set wins
            if (evict)
            begin
                valid_next[vic_idx_reg] = 1'b0;
            end
            valid_next[tgt_next] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            filled_reg    <= '0;
            all_reg       <= 1'b0;
            res_found_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            tgt_reg       <= tgt_next;
            thr_reg       <= hit_reg ? hit_rank_reg : vic_rank_reg;
            all_reg       <= !hit_reg && !evict;
            new_data_reg  <= is_put ? data_reg : hit_data_reg;
            new_cnt_reg   <= !hit_reg ? COUNT_WIDTH'(1) :
                             (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg :
                             hit_cnt_reg + 1'b1;
            res_found_reg <= !is_put && hit_reg;
            res_value_reg <= (!is_put && hit_reg) ? hit_data_reg : '0;
            valid_reg     <= valid_next;
            if (need_update && !hit_reg && !evict)
            begin
                filled_reg <= filled_reg + 1'b1;
            end
        end
    end

    // update sweep: age the younger entries, rewrite the target
    always_comb
    begin
        wr_en   = 1'b0;
        wr_word = rd_word_reg;
        if (cmd.update && pv_reg)
        begin
            priority if (pidx_reg == tgt_reg)
            begin
                wr_en   = 1'b1;
                wr_word = {key_reg, new_data_reg, new_cnt_reg, {RW{1'b0}}};
            end
            else if (rd_valid && (all_reg || rd_rank < thr_reg))
            begin
                wr_en            = 1'b1;
                wr_word[RW-1:0]  = rd_rank + 1'b1;
            end
            else
            begin
                wr_en = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            out_valid_reg  <= 1'b1;
            found_reg      <= res_found_reg;
            read_value_reg <= res_value_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.sweep_done  = (ctr_reg == CTR_END) && !pv_reg;
    assign status.need_update = need_update;
    assign status.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire
